[hdl/srbal_pkg.sv]
// shared types and constants for the scan ring buffer with angle lookup
package srbal_pkg;

  localparam int DEFAULT_SCAN_SLOTS      = 8;
  localparam int DEFAULT_VALUES_PER_SLOT = 256;

  localparam int DIST_W     = 16;
  localparam int POS_W      = 8;
  localparam int STEP_W     = 8;
  localparam int ANGLE_W    = 13;
  localparam int ACT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int DIV_W      = 8;

  // full sweep in whole degrees and in q8.4 degrees
  localparam logic [DIV_W-1:0]          FULL_SCAN_DEG = 8'd180;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX_Q4  = 13'sd2880;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

[hdl/srbal_ram.sv]
// generic single-write, single-read ram with registered read data
module srbal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/srbal_div.sv]
// iterative restoring divider, one quotient bit per cycle
module srbal_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [srbal_pkg::DIV_W-1:0] dividend,
  input  logic [srbal_pkg::DIV_W-1:0] divisor,
  output logic [srbal_pkg::DIV_W-1:0] quotient,
  output logic                       done
);
  import srbal_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? DIV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[hdl/scan_ring_buffer_angle_lookup.sv]
// scan ring buffer top level: scan store, per-slot info and the sequencing fsm
// path from accept to result: clear or empty/range answer goes straight to S_DONE,
// push via S_PUSH, push that opens a scan via S_OPEN and S_PUSH, pop via S_INFO and
// S_READ, distance query via S_DIV, S_INFO and S_READ; info and store reads are registered
// one word in work at a time; a new word is taken while the previous result waits at out_
// the 8-step shared divider runs in S_OPEN and S_DIV
// synchronous active-low reset empties the ring and sets the resolution to one degree
module scan_ring_buffer_angle_lookup #(
  parameter int SCAN_SLOTS      = srbal_pkg::DEFAULT_SCAN_SLOTS,
  parameter int VALUES_PER_SLOT = srbal_pkg::DEFAULT_VALUES_PER_SLOT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] sample_distance, [28:16] query_angle, [31:29] zero
  input  logic [srbal_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,   // sample_last
  input  logic [srbal_pkg::ACT_W-1:0]      in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [srbal_pkg::OUT_DATA_W-1:0] out_tdata,  // distance_out
  output logic                             out_tlast,  // scan_end
  output logic [srbal_pkg::STATUS_W-1:0]   out_tuser,  // status
  input  logic                             cfg_we,
  input  logic [srbal_pkg::STEP_W-1:0]     cfg_wdata   // angle_step_degrees
);
  import srbal_pkg::*;

  localparam int SLOT_W      = $clog2(SCAN_SLOTS);
  localparam int CNT_W       = $clog2(SCAN_SLOTS + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int STORE_DEPTH = SCAN_SLOTS * VALUES_PER_SLOT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int INFO_W      = 2 * POS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_OPEN = 7'b0000010,   // divider works out the length of a new scan
    S_PUSH = 7'b0000100,   // store write and scan close
    S_DIV  = 7'b0001000,   // divider works out the query index
    S_INFO = 7'b0010000,   // slot info arrives, store read goes out
    S_READ = 7'b0100000,   // store data arrives
    S_DONE = 7'b1000000    // result waits for the output register
  } state_t;

  // ring position with wraparound, offset never reaches twice the slot count
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(SCAN_SLOTS)) begin
      sum = sum - SUM_W'(SCAN_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0]  pos);
    return STORE_AW'(slot) * STORE_AW'(VALUES_PER_SLOT) + STORE_AW'(pos);
  endfunction

  // control state
  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r;
  logic [SLOT_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [POS_W-1:0]     fill_pos_r, fill_pos_nxt;
  logic                 recv_r, recv_nxt;
  logic [POS_W-1:0]     pop_pos_r, pop_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload held across the item's cycles
  action_t              act_r, act_nxt;
  logic [DIST_W-1:0]    sample_r, sample_nxt;
  logic                 last_r, last_nxt;
  logic [SLOT_W-1:0]    fill_slot_r, fill_slot_nxt;
  logic [POS_W-1:0]     fill_len_r, fill_len_nxt;
  logic [SLOT_W-1:0]    rd_slot_r, rd_slot_nxt;
  logic                 zero_r, zero_nxt;
  logic                 end_r, end_nxt;
  logic [DIST_W-1:0]    res_dist_r, res_dist_nxt;
  logic                 res_end_r, res_end_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [DIST_W-1:0]    out_dist_r, out_dist_nxt;
  logic                 out_end_r, out_end_nxt;
  status_t              out_status_r, out_status_nxt;

  // input word fields
  action_t              in_act;
  logic [DIST_W-1:0]    in_sample;
  logic signed [ANGLE_W-1:0] in_angle;
  logic                 in_fire;
  logic                 ring_full;
  logic [STEP_W-1:0]    step_eff;

  // divider
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_quo;
  logic                 div_done;

  // memories
  logic                 store_we, store_re;
  logic [STORE_AW-1:0]  store_waddr, store_raddr;
  logic [DIST_W-1:0]    store_rdata;
  logic                 info_we, info_re;
  logic [SLOT_W-1:0]    info_waddr, info_raddr;
  logic [INFO_W-1:0]    info_wdata, info_rdata;

  // lookup helpers
  logic [POS_W-1:0]     info_len, info_fill, base_pos, rd_pos;
  logic [POS_W-1:0]     fill_after;
  logic                 fill_room;

  assign in_act    = action_t'(in_tuser);
  assign in_sample = in_tdata[DIST_W-1:0];
  assign in_angle  = in_tdata[DIST_W +: ANGLE_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ring_full = (count_r == CNT_W'(SCAN_SLOTS));
  // a zero resolution acts as one degree
  assign step_eff  = (step_r == '0) ? STEP_W'(1) : step_r;

  // slot info layout: fill count above, scan length below
  assign info_len  = info_rdata[POS_W-1:0];
  assign info_fill = info_rdata[INFO_W-1:POS_W];
  assign base_pos  = (act_r == ACT_POP) ? pop_pos_r : div_quo;
  assign rd_pos    = (base_pos < info_len) ? base_pos : info_len - 1'b1;
  assign fill_room = (fill_pos_r < fill_len_r);
  assign fill_after = fill_room ? fill_pos_r + 1'b1 : fill_pos_r;

  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    fill_pos_nxt   = fill_pos_r;
    recv_nxt       = recv_r;
    pop_pos_nxt    = pop_pos_r;
    act_nxt        = act_r;
    sample_nxt     = sample_r;
    last_nxt       = last_r;
    fill_slot_nxt  = fill_slot_r;
    fill_len_nxt   = fill_len_r;
    rd_slot_nxt    = rd_slot_r;
    zero_nxt       = zero_r;
    end_nxt        = end_r;
    res_dist_nxt   = res_dist_r;
    res_end_nxt    = res_end_r;
    res_status_nxt = res_status_r;
    out_dist_nxt   = out_dist_r;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    div_start    = 1'b0;
    div_dividend = FULL_SCAN_DEG;
    store_we     = 1'b0;
    store_waddr  = store_addr(fill_slot_r, fill_pos_r);
    store_re     = 1'b0;
    store_raddr  = store_addr(rd_slot_r, rd_pos);
    info_we      = 1'b0;
    info_waddr   = fill_slot_r;
    info_wdata   = {fill_after, fill_len_r};
    info_re      = 1'b0;
    info_raddr   = oldest_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_act;
          sample_nxt     = in_sample;
          last_nxt       = in_tlast;
          res_dist_nxt   = '0;
          res_end_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          end_nxt        = 1'b0;
          unique case (in_act)
            ACT_PUSH: begin
              if (recv_r) begin
                state_nxt = S_PUSH;
              end else begin
                // open a scan; a full ring gives up its oldest scan, whose slot is reused
                if (ring_full) begin
                  oldest_nxt    = slot_add(oldest_r, CNT_W'(1));
                  count_nxt     = count_r - 1'b1;
                  pop_pos_nxt   = '0;
                  fill_slot_nxt = oldest_r;
                end else begin
                  fill_slot_nxt = slot_add(oldest_r, count_r);
                end
                div_start    = 1'b1;
                div_dividend = FULL_SCAN_DEG;
                state_nxt    = S_OPEN;
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                rd_slot_nxt = oldest_r;
                info_re     = 1'b1;
                info_raddr  = oldest_r;
                state_nxt   = S_INFO;
              end
            end
            ACT_CLEAR: begin
              count_nxt    = '0;
              oldest_nxt   = '0;
              recv_nxt     = 1'b0;
              fill_pos_nxt = '0;
              pop_pos_nxt  = '0;
              state_nxt    = S_DONE;
            end
            ACT_QUERY: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else if (in_angle < 0 || in_angle > ANGLE_MAX_Q4) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                // index is whole degrees over the resolution
                rd_slot_nxt  = slot_add(oldest_r, count_r - 1'b1);
                div_start    = 1'b1;
                div_dividend = in_angle[ANGLE_W-2:4];
                state_nxt    = S_DIV;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OPEN: begin
        if (div_done) begin
          fill_len_nxt = div_quo + 1'b1;
          fill_pos_nxt = '0;
          recv_nxt     = 1'b1;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        // samples past the scan length are dropped
        if (fill_room) begin
          store_we     = 1'b1;
          fill_pos_nxt = fill_after;
        end
        if (last_r) begin
          // slot info records how many entries this scan wrote; the rest read as zero
          info_we      = 1'b1;
          recv_nxt     = 1'b0;
          fill_pos_nxt = '0;
          count_nxt    = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          info_re    = 1'b1;
          info_raddr = rd_slot_r;
          state_nxt  = S_INFO;
        end
      end
      S_INFO: begin
        store_re = 1'b1;
        zero_nxt = (rd_pos >= info_fill);
        if (act_r == ACT_POP) begin
          if (rd_pos == info_len - 1'b1) begin
            end_nxt     = 1'b1;
            oldest_nxt  = slot_add(oldest_r, CNT_W'(1));
            count_nxt   = count_r - 1'b1;
            pop_pos_nxt = '0;
          end else begin
            pop_pos_nxt = rd_pos + 1'b1;
          end
        end
        state_nxt = S_READ;
      end
      S_READ: begin
        res_dist_nxt = zero_r ? '0 : store_rdata;
        res_end_nxt  = end_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = res_dist_r;
          out_end_nxt    = res_end_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_W'(1);
      oldest_r    <= '0;
      count_r     <= '0;
      fill_pos_r  <= '0;
      recv_r      <= 1'b0;
      pop_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      fill_pos_r  <= fill_pos_nxt;
      recv_r      <= recv_nxt;
      pop_pos_r   <= pop_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    sample_r     <= sample_nxt;
    last_r       <= last_nxt;
    fill_slot_r  <= fill_slot_nxt;
    fill_len_r   <= fill_len_nxt;
    rd_slot_r    <= rd_slot_nxt;
    zero_r       <= zero_nxt;
    end_r        <= end_nxt;
    res_dist_r   <= res_dist_nxt;
    res_end_r    <= res_end_nxt;
    res_status_r <= res_status_nxt;
    out_dist_r   <= out_dist_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
  end

  // shared divider: scan length at open, angle index at query
  srbal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (step_eff),
    .quotient (div_quo),
    .done     (div_done)
  );

  // distance samples, one row of VALUES_PER_SLOT per ring slot
  srbal_ram #(
    .WIDTH (DIST_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (sample_r),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // per-slot length and fill count, written when a scan closes
  srbal_ram #(
    .WIDTH (INFO_W),
    .DEPTH (SCAN_SLOTS)
  ) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (info_re),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dist_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_status_r;

endmodule

[hdl/srbal_checker.sv]
// port-level checks for the scan ring buffer, bound to the top level
module srbal_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [srbal_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [srbal_pkg::STATUS_W-1:0]   out_tuser
);
  import srbal_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // end of scan only comes with a good pop
  a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_OK)
    else $error("scan end with error status");

  // empty or out-of-range answers carry no distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_RANGE)
      |-> out_tdata == '0 && !out_tlast)
    else $error("error result carries data");

  // one word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind scan_ring_buffer_angle_lookup srbal_checker u_srbal_checker (.*);
